/* rtl/ll1_pkg.sv */
package ll1_pkg;

  localparam int unsigned SymW   = 6;
  localparam int unsigned TermW  = 5;
  localparam int unsigned NtW    = 5;
  localparam int unsigned ProdW  = 6;
  localparam int unsigned PosW   = 3;
  localparam int unsigned LenW   = 4;
  localparam int unsigned CntW   = 10;
  localparam int unsigned TotW   = 16;
  localparam int unsigned DepthW = 7;
  localparam int unsigned StatW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned DefMaxTerminals    = 32;
  localparam int unsigned DefMaxNonterminals = 32;
  localparam int unsigned DefMaxProductions  = 64;
  localparam int unsigned DefMaxBody         = 8;
  localparam int unsigned DefStackDepth      = 64;

  typedef enum logic [2:0] {
    FUNC_START  = 3'd0,
    FUNC_TOKEN  = 3'd1,
    FUNC_CELL   = 3'd2,
    FUNC_BODY   = 3'd3,
    FUNC_LENGTH = 3'd4,
    FUNC_FOLLOW = 3'd5
  } func_t;

  typedef enum logic [StatW-1:0] {
    ST_LOADED   = 4'd0,
    ST_STARTED  = 4'd1,
    ST_MATCHED  = 4'd2,
    ST_SKIPPED  = 4'd3,
    ST_ACCEPTED = 4'd4,
    ST_FAILED   = 4'd5,
    ST_OVERFLOW = 4'd6,
    ST_STEPLIM  = 4'd7,
    ST_IDLE     = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_FIRST = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PARSING = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_READ,
    S_DECIDE,
    S_CELL,
    S_LEN,
    S_BADDR,
    S_PUSH,
    S_OUT
  } fsm_t;

endpackage

/* rtl/ll1_predictive_parser.sv */
// Channel | Dir | Fields (low bit first)
// in_     | in  | func, symbol, nonterminal_index, terminal_index, production_index,
//         |     | body_position, body_length, flag
// out_    | out | status, errors_this_token, expansions, total_errors, stack_depth
// cfg_    | in  | write enable, register index, data
// After reset a clearing pass over all MAX_NONTERMINALS * MAX_TERMINALS cells (1024 by
// default) zeroes the table cells and follow bits; in_tready stays low meanwhile.
// A loader word raises out_tvalid the cycle after acceptance, a start word after S_START.
// A token passes S_READ (stack read) and S_DECIDE per stack step, S_CELL (cell and
// follow read) and S_LEN (length read) for a nonterminal top, and S_BADDR and S_PUSH
// per pushed body symbol. A stalled out_tready holds the result and blocks the next word.
module ll1_predictive_parser #(
  parameter int unsigned MAX_TERMINALS    = ll1_pkg::DefMaxTerminals,
  parameter int unsigned MAX_NONTERMINALS = ll1_pkg::DefMaxNonterminals,
  parameter int unsigned MAX_PRODUCTIONS  = ll1_pkg::DefMaxProductions,
  parameter int unsigned MAX_BODY         = ll1_pkg::DefMaxBody,
  parameter int unsigned STACK_DEPTH      = ll1_pkg::DefStackDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // func[2:0], symbol[8:3], nonterminal_index[13:9], terminal_index[18:14],
  // production_index[24:19], body_position[27:25], body_length[31:28], flag[32]
  input  logic [ll1_pkg::InDataW-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[3:0], errors_this_token[13:4], expansions[23:14],
  // total_errors[39:24], stack_depth[46:40]
  output logic [ll1_pkg::OutDataW-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [ll1_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ll1_pkg::CfgDataW-1:0] cfg_data
);
  import ll1_pkg::*;

  localparam int unsigned CellN = MAX_NONTERMINALS * MAX_TERMINALS;
  localparam int unsigned CellW = (CellN > 1) ? $clog2(CellN) : 1;
  localparam int unsigned PrW   = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
  localparam int unsigned BdW   = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int unsigned BsN   = MAX_PRODUCTIONS * MAX_BODY;
  localparam int unsigned BsW   = PrW + BdW;
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned StW   = $clog2(STACK_DEPTH);
  localparam int unsigned BlW   = $clog2(MAX_BODY + 1);

  // Configuration.
  logic [SymW-1:0]  start_sym_r, first_nt_r;
  logic [TermW-1:0] end_sym_r;
  logic [CntW-1:0]  step_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_sym_r <= SymW'(32);
      end_sym_r   <= '0;
      first_nt_r  <= SymW'(32);
      step_lim_r  <= CntW'(256);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START: start_sym_r <= cfg_data[SymW-1:0];
        CFG_END:   end_sym_r   <= cfg_data[TermW-1:0];
        CFG_FIRST: first_nt_r  <= cfg_data[SymW-1:0];
        CFG_LIMIT: step_lim_r  <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [2:0]       f_func;
  logic [SymW-1:0]  f_sym;
  logic [ProdW-1:0] f_prod;
  logic [NtW-1:0]   f_nt;
  logic [TermW-1:0] f_term;
  logic [PosW-1:0]  f_pos;
  logic [LenW-1:0]  f_len;
  logic             f_flag;
  assign f_func = in_tdata[2:0];
  assign f_sym  = in_tdata[8:3];
  assign f_nt   = in_tdata[13:9];
  assign f_term = in_tdata[18:14];
  assign f_prod = in_tdata[24:19];
  assign f_pos  = in_tdata[27:25];
  assign f_len  = in_tdata[31:28];
  assign f_flag = in_tdata[32];

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // Memories. A table cell holds its valid bit above the production number.
  logic [SymW-1:0] stack_mem  [STACK_DEPTH];
  logic [PrW:0]    cell_mem   [CellN];
  logic            follow_mem [CellN];
  logic [SymW-1:0] body_mem   [BsN];
  logic [BlW-1:0]  len_mem    [MAX_PRODUCTIONS];

  // Control state.
  fsm_t             state_r, state_nxt;
  phase_t           phase_r;
  logic [CellW-1:0] clr_r;
  logic [SpW-1:0]   sp_r;
  logic [TotW-1:0]  total_r;
  logic [CntW-1:0]  errs_r, exps_r, steps_r;
  logic [SymW-1:0]  tok_r;
  logic [StatW-1:0] status_r;
  logic [BlW-1:0]   push_cnt_r;
  logic [PrW-1:0]   prod_r;

  // Read data.
  logic [SymW-1:0] top_q;
  logic [PrW:0]    cell_q;
  logic            follow_q;
  logic [BlW-1:0]  len_q;
  logic [SymW-1:0] body_q;

  // Cell address from the stack top and token.
  logic [SymW-1:0] nt_val;
  logic            row_ok, col_ok;
  logic [CellW-1:0] cell_addr;
  assign nt_val = top_q - first_nt_r;
  assign row_ok = {1'b0, top_q} >= {1'b0, first_nt_r} && 32'(nt_val) < MAX_NONTERMINALS;
  assign col_ok = 32'(tok_r) < MAX_TERMINALS;
  assign cell_addr = CellW'(32'(nt_val) * MAX_TERMINALS + 32'(tok_r));

  logic [StW-1:0] stack_raddr;
  logic [BsW-1:0] body_raddr;
  assign stack_raddr = StW'(sp_r - SpW'(1));
  assign body_raddr  = BsW'(32'(prod_r) * MAX_BODY + 32'(push_cnt_r) - 32'd1);

  // The length read is addressed straight from the cell data, so it is valid
  // in the cycle after the cell itself.
  always_ff @(posedge clk) begin
    top_q    <= stack_mem[stack_raddr];
    body_q   <= body_mem[body_raddr];
    cell_q   <= cell_mem[cell_addr];
    follow_q <= follow_mem[cell_addr];
    len_q    <= len_mem[cell_q[PrW-1:0]];
  end

  // Decision combinational.
  logic is_term, do_match, do_accept, cell_hit, follow_hit, len_ovf, step_stop;
  assign is_term    = top_q < first_nt_r;
  assign do_accept  = top_q == SymW'(end_sym_r) && tok_r == SymW'(end_sym_r);
  assign do_match   = top_q == tok_r;
  assign cell_hit   = row_ok && col_ok && cell_q[PrW];
  assign follow_hit = row_ok && col_ok && follow_q;
  assign len_ovf    = 32'(sp_r) + 32'(len_q) > STACK_DEPTH + 32'd1;
  assign step_stop  = sp_r == '0 || steps_r >= step_lim_r;

  function automatic logic [TotW-1:0] sat_inc(input logic [TotW-1:0] v);
    sat_inc = (v == '1) ? v : v + TotW'(1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == CellW'(CellN - 1)) state_nxt = S_IDLE;
      S_IDLE:
        if (in_fire) begin
          if (func_t'(f_func) == FUNC_START) state_nxt = S_START;
          else if (func_t'(f_func) == FUNC_TOKEN && phase_r == PH_PARSING)
            state_nxt = S_READ;
          else state_nxt = S_OUT;
        end
      S_START:  state_nxt = S_OUT;
      S_READ:   state_nxt = step_stop ? S_OUT : S_DECIDE;
      S_DECIDE:
        if (do_accept || do_match) state_nxt = S_OUT;
        else if (is_term) state_nxt = S_READ;
        else state_nxt = S_CELL;
      S_CELL:
        if (cell_hit) state_nxt = S_LEN;
        else if (follow_hit) state_nxt = S_READ;
        else state_nxt = S_OUT;
      S_LEN:
        if (len_ovf) state_nxt = S_OUT;
        else if (len_q == '0) state_nxt = S_READ;
        else state_nxt = S_BADDR;
      S_BADDR:  state_nxt = S_PUSH;
      S_PUSH:   state_nxt = (push_cnt_r == BlW'(1)) ? S_READ : S_BADDR;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = state_r == S_IDLE;
    out_tvalid = state_r == S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      phase_r <= PH_IDLE;
      sp_r    <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_CLEAR: begin
          cell_mem[clr_r]   <= '0;
          follow_mem[clr_r] <= 1'b0;
          clr_r <= clr_r + CellW'(1);
        end
        S_IDLE: if (in_fire) begin
          errs_r  <= '0;
          exps_r  <= '0;
          steps_r <= '0;
          tok_r   <= f_sym;
          status_r <= ST_LOADED;
          case (func_t'(f_func))
            FUNC_START: begin
              stack_mem[StW'(0)] <= SymW'(end_sym_r);
              sp_r     <= SpW'(2);
              total_r  <= '0;
              phase_r  <= PH_PARSING;
              status_r <= ST_STARTED;
            end
            FUNC_TOKEN:
              if (phase_r != PH_PARSING) status_r <= ST_IDLE;
            FUNC_CELL:
              if (32'(f_nt) < MAX_NONTERMINALS && 32'(f_term) < MAX_TERMINALS &&
                  32'(f_prod) < MAX_PRODUCTIONS)
                cell_mem[CellW'(32'(f_nt) * MAX_TERMINALS + 32'(f_term))] <=
                  f_flag ? {1'b1, PrW'(f_prod)} : '0;
            FUNC_BODY:
              if (32'(f_prod) < MAX_PRODUCTIONS && 32'(f_pos) < MAX_BODY)
                body_mem[BsW'(32'(f_prod) * MAX_BODY + 32'(f_pos))] <= f_sym;
            FUNC_LENGTH:
              if (32'(f_prod) < MAX_PRODUCTIONS)
                len_mem[PrW'(f_prod)] <= (32'(f_len) > MAX_BODY) ? BlW'(MAX_BODY)
                                                                : BlW'(f_len);
            FUNC_FOLLOW:
              if (32'(f_nt) < MAX_NONTERMINALS && 32'(f_term) < MAX_TERMINALS)
                follow_mem[CellW'(32'(f_nt) * MAX_TERMINALS + 32'(f_term))] <= f_flag;
            default: status_r <= ST_IDLE;
          endcase
        end
        S_START: stack_mem[StW'(1)] <= start_sym_r;
        S_READ: begin
          // Stack top read is in flight; checks that need no memory data.
          if (sp_r == '0) begin
            status_r <= ST_FAILED; phase_r <= PH_DONE;
          end else if (steps_r >= step_lim_r) begin
            status_r <= ST_STEPLIM; phase_r <= PH_DONE;
          end else begin
            steps_r <= steps_r + CntW'(1);
          end
        end
        S_DECIDE: begin
          if (do_accept) begin
            status_r <= ST_ACCEPTED; phase_r <= PH_DONE;
          end else if (do_match) begin
            sp_r <= sp_r - SpW'(1); status_r <= ST_MATCHED;
          end else if (is_term) begin
            errs_r  <= errs_r + CntW'(1);
            total_r <= sat_inc(total_r);
            sp_r    <= sp_r - SpW'(1);
          end
        end
        S_CELL: begin
          if (cell_hit) begin
            prod_r <= cell_q[PrW-1:0];
          end else begin
            errs_r  <= errs_r + CntW'(1);
            total_r <= sat_inc(total_r);
            if (follow_hit) begin
              sp_r <= sp_r - SpW'(1);
            end else if (tok_r == SymW'(end_sym_r)) begin
              status_r <= ST_FAILED; phase_r <= PH_DONE;
            end else begin
              status_r <= ST_SKIPPED;
            end
          end
        end
        S_LEN: begin
          if (len_ovf) begin
            status_r <= ST_OVERFLOW; phase_r <= PH_DONE;
          end else begin
            sp_r       <= sp_r - SpW'(1);
            push_cnt_r <= len_q;
            exps_r     <= exps_r + CntW'(1);
          end
        end
        S_BADDR: ;
        S_PUSH: begin
          // The body goes on last symbol first, so its first symbol ends on top.
          stack_mem[StW'(sp_r)] <= body_q;
          sp_r       <= sp_r + SpW'(1);
          push_cnt_r <= push_cnt_r - BlW'(1);
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  assign out_tdata = {1'b0, DepthW'(sp_r), total_r, exps_r, errs_r, status_r};

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH) else $error("stack pointer beyond depth");
  a_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |-> steps_r != '0) else $error("decide without a step");
endmodule
